@@ sv/srt_pkg.sv @@
// srt_pkg: types, codes and sizes shared by the sorted record table.
// Depends on nothing; imported by every module of the block.
package srt_pkg;

    localparam int CAPACITY   = 64;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = IDX_W + 1;
    localparam int MODE_W     = 3;
    localparam int KEY_W      = 32;
    localparam int ID_W       = 32;
    localparam int CAT_W      = 8;
    localparam int POS_W      = 6;
    localparam int ST_W       = 2;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 80;

    localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MODIFY   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOOKUP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DUMP_FWD = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DUMP_REV = 3'd5;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd3;

    typedef logic [1:0] t_sel;

    // write data source
    localparam t_sel WR_SHIFT = 2'd0;
    localparam t_sel WR_INS   = 2'd1;
    localparam t_sel WR_MOD   = 2'd2;

    // result data source
    localparam t_sel SRC_ZERO = 2'd0;
    localparam t_sel SRC_MEM  = 2'd1;
    localparam t_sel SRC_INS  = 2'd2;
    localparam t_sel SRC_MOD  = 2'd3;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [ID_W-1:0]  id_number;
        logic [CAT_W-1:0]        category;
    } t_rec;

    typedef struct packed {
        logic             cap;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_sel             wr_src;
        logic             cnt_inc;
        logic             cnt_dec;
        logic             out_load;
        logic [ST_W-1:0]  out_st;
        t_sel             out_src;
        logic [IDX_W-1:0] out_pos;
        logic             out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             key_ge;
        logic             key_eq;
        logic             out_free;
    } t_dp_sts;

endpackage

@@ sv/srt_ctrl.sv @@
// srt_ctrl: sequencer of the sorted record table (scan, shift, dump, result).
// Depends on srt_pkg; drives srt_dp through t_dp_cmd.
module srt_ctrl import srt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [MODE_W-1:0] i_mode,
    input  t_dp_sts           i_sts,
    output logic              o_ready,
    output t_dp_cmd           o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_SHUP   = 4'd3;
    localparam logic [3:0] S_WRITE  = 4'd4;
    localparam logic [3:0] S_EMIT   = 4'd5;
    localparam logic [3:0] S_SHDN   = 4'd6;
    localparam logic [3:0] S_DUMP   = 4'd7;

    logic [3:0]        r_state, n_state;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [ST_W-1:0]   r_st, n_st;
    t_sel              r_src, n_src;

    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] idx_p1;
    logic [CNT_W-1:0] pos_p1;
    logic             hit;

    assign cnt_m1 = i_sts.cnt - CNT_W'(1);
    assign idx_p1 = {1'b0, r_idx} + CNT_W'(1);
    assign pos_p1 = {1'b0, r_pos} + CNT_W'(1);
    assign hit    = (r_mode == MODE_INSERT) ? i_sts.key_ge : i_sts.key_eq;
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_idx   = r_idx;
        n_pos   = r_pos;
        n_st    = r_st;
        n_src   = r_src;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.cap = 1'b1;
                    n_mode    = i_mode;
                    n_state   = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_mode == MODE_INSERT) begin
                    if (i_sts.cnt == CNT_W'(CAPACITY)) begin
                        n_st    = ST_FULL;
                        n_src   = SRC_ZERO;
                        n_pos   = '0;
                        n_state = S_EMIT;
                    end else if (i_sts.cnt == '0) begin
                        n_pos   = '0;
                        n_state = S_WRITE;
                    end else begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_addr = '0;
                        n_idx         = '0;
                        n_state       = S_SCAN;
                    end
                end else if (r_mode > MODE_DUMP_REV) begin
                    n_state = S_IDLE;
                end else if (i_sts.cnt == '0) begin
                    n_st    = ST_EMPTY;
                    n_src   = SRC_ZERO;
                    n_pos   = '0;
                    n_state = S_EMIT;
                end else if (r_mode == MODE_DUMP_FWD || r_mode == MODE_DUMP_REV) begin
                    n_idx = (r_mode == MODE_DUMP_FWD) ? '0 : cnt_m1[IDX_W-1:0];
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = n_idx;
                    n_state       = S_DUMP;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = '0;
                    n_idx         = '0;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_pos = r_idx;
                    if (r_mode == MODE_INSERT) begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_addr = cnt_m1[IDX_W-1:0];
                        n_idx         = cnt_m1[IDX_W-1:0];
                        n_state       = S_SHUP;
                    end else if (r_mode == MODE_MODIFY) begin
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.wr_addr = r_idx;
                        o_cmd.wr_src  = WR_MOD;
                        n_st          = ST_OK;
                        n_src         = SRC_MOD;
                        n_state       = S_EMIT;
                    end else begin
                        n_st    = ST_OK;
                        n_src   = SRC_MEM;
                        n_state = S_EMIT;
                    end
                end else if (idx_p1 == i_sts.cnt) begin
                    if (r_mode == MODE_INSERT) begin
                        n_pos   = i_sts.cnt[IDX_W-1:0];
                        n_state = S_WRITE;
                    end else begin
                        n_st    = ST_NOT_FOUND;
                        n_src   = SRC_ZERO;
                        n_pos   = '0;
                        n_state = S_EMIT;
                    end
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = idx_p1[IDX_W-1:0];
                    n_idx         = idx_p1[IDX_W-1:0];
                end
            end
            S_SHUP: begin
                // move entry up by one, walking down towards the insert slot
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = idx_p1[IDX_W-1:0];
                o_cmd.wr_src  = WR_SHIFT;
                if (r_idx == r_pos) begin
                    n_state = S_WRITE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = r_idx - IDX_W'(1);
                    n_idx         = r_idx - IDX_W'(1);
                end
            end
            S_WRITE: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_pos;
                o_cmd.wr_src  = WR_INS;
                o_cmd.cnt_inc = 1'b1;
                n_st          = ST_OK;
                n_src         = SRC_INS;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_st   = r_st;
                    o_cmd.out_src  = r_src;
                    o_cmd.out_pos  = r_pos;
                    o_cmd.out_last = 1'b1;
                    if (r_mode == MODE_DELETE && r_st == ST_OK) begin
                        if (pos_p1 == i_sts.cnt) begin
                            o_cmd.cnt_dec = 1'b1;
                            n_state       = S_IDLE;
                        end else begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_addr = pos_p1[IDX_W-1:0];
                            n_idx         = pos_p1[IDX_W-1:0];
                            n_state       = S_SHDN;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SHDN: begin
                // close the gap left by a delete
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_idx - IDX_W'(1);
                o_cmd.wr_src  = WR_SHIFT;
                if (idx_p1 == i_sts.cnt) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = idx_p1[IDX_W-1:0];
                    n_idx         = idx_p1[IDX_W-1:0];
                end
            end
            S_DUMP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_st   = ST_OK;
                    o_cmd.out_src  = SRC_MEM;
                    o_cmd.out_pos  = r_idx;
                    if (r_mode == MODE_DUMP_FWD) begin
                        o_cmd.out_last = (idx_p1 == i_sts.cnt);
                        n_idx          = idx_p1[IDX_W-1:0];
                    end else begin
                        o_cmd.out_last = (r_idx == '0);
                        n_idx          = r_idx - IDX_W'(1);
                    end
                    if (o_cmd.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_addr = n_idx;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_INSERT;
            r_idx   <= '0;
            r_pos   <= '0;
            r_st    <= ST_OK;
            r_src   <= SRC_ZERO;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_idx   <= n_idx;
            r_pos   <= n_pos;
            r_st    <= n_st;
            r_src   <= n_src;
        end
    end

endmodule

@@ sv/srt_dp.sv @@
// srt_dp: record memory, entry count, item registers, key compare, result register.
// Depends on srt_pkg; commanded by srt_ctrl.
module srt_dp import srt_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic signed [ID_W-1:0]  i_id_number,
    input  logic [CAT_W-1:0]        i_category,
    input  logic signed [KEY_W-1:0] i_new_key,
    input  logic                    i_out_ready,
    output t_dp_sts                 o_sts,
    output logic                    o_out_valid,
    output logic [ST_W-1:0]         o_out_status,
    output t_rec                    o_out_rec,
    output logic [POS_W-1:0]        o_out_pos,
    output logic                    o_out_last
);

    t_rec mem [CAPACITY];

    t_rec                    r_rd;
    logic signed [KEY_W-1:0] r_key;
    logic signed [ID_W-1:0]  r_id_number;
    logic [CAT_W-1:0]        r_category;
    logic signed [KEY_W-1:0] r_new_key;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_out_valid;
    logic [ST_W-1:0]         r_out_st;
    t_rec                    r_out_rec;
    logic [POS_W-1:0]        r_out_pos;
    logic                    r_out_last;

    t_rec wr_data;
    t_rec out_data;
    logic out_free;

    always_comb begin
        case (i_cmd.wr_src)
            WR_INS:  wr_data = '{key: r_key, id_number: r_id_number, category: r_category};
            WR_MOD:  wr_data = '{key: r_new_key, id_number: r_id_number,
                                 category: r_category};
            default: wr_data = r_rd;
        endcase
    end

    always_comb begin
        case (i_cmd.out_src)
            SRC_MEM: out_data = r_rd;
            SRC_INS: out_data = '{key: r_key, id_number: r_id_number, category: r_category};
            SRC_MOD: out_data = '{key: r_new_key, id_number: r_id_number,
                                  category: r_category};
            default: out_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_cmd.wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_key       <= i_key;
            r_id_number <= i_id_number;
            r_category  <= i_category;
            r_new_key   <= i_new_key;
        end
        if (i_cmd.out_load) begin
            r_out_st   <= i_cmd.out_st;
            r_out_rec  <= out_data;
            r_out_pos  <= POS_W'(i_cmd.out_pos);
            r_out_last <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign out_free       = !r_out_valid || i_out_ready;
    assign o_sts.cnt      = r_cnt;
    assign o_sts.key_ge   = (r_rd.key >= r_key);
    assign o_sts.key_eq   = (r_rd.key == r_key);
    assign o_sts.out_free = out_free;
    assign o_out_valid    = r_out_valid;
    assign o_out_status   = r_out_st;
    assign o_out_rec      = r_out_rec;
    assign o_out_pos      = r_out_pos;
    assign o_out_last     = r_out_last;

endmodule

@@ sv/sorted_record_table.sv @@
// sorted_record_table: bounded table of records kept in ascending signed key order.
// Depends on srt_pkg, srt_ctrl and srt_dp.
//
// Input channel (s side): one item per operation; tuser carries the mode
// (insert, modify, delete, lookup, dump forward, dump reverse), tdata the key,
// id number, category and replacement key. Output channel (m side): one result
// per operation, or one per stored record for a dump; tuser is the status,
// tlast marks the final result of an operation.
// Items are taken one at a time: o_s_tready is high only while no operation is
// in progress. Records live in a single-port-read memory that is walked one
// entry per cycle, except while a stalled receiver holds a dump. Unused modes
// give no result.
// The last result sits in an output register, so the next item is taken while
// it waits; a stalled receiver holds the walk of the table until it drains.
// Synchronous active-low reset empties the table; no clearing pass is needed.
module sorted_record_table import srt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [31:0] key, [63:32] id_number, [71:64] category, [103:72] new_key
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // [2:0] mode
    input  logic [MODE_W-1:0]     i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [31:0] out_key, [63:32] out_id_number, [71:64] out_category,
    // [77:72] position, [79:78] zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // [1:0] status
    output logic [ST_W-1:0]       o_m_tuser,
    output logic                  o_m_tlast
);

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic             accept;
    t_rec             out_rec;
    logic [POS_W-1:0] out_pos;

    assign accept = i_s_tvalid && o_s_tready;

    srt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_mode   (i_s_tuser),
        .i_sts    (sts),
        .o_ready  (o_s_tready),
        .o_cmd    (cmd)
    );

    srt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_key        (i_s_tdata[31:0]),
        .i_id_number  (i_s_tdata[63:32]),
        .i_category   (i_s_tdata[71:64]),
        .i_new_key    (i_s_tdata[103:72]),
        .i_out_ready  (i_m_tready),
        .o_sts        (sts),
        .o_out_valid  (o_m_tvalid),
        .o_out_status (o_m_tuser),
        .o_out_rec    (out_rec),
        .o_out_pos    (out_pos),
        .o_out_last   (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, out_pos, out_rec.category, out_rec.id_number, out_rec.key};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.cnt <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result register overwritten while held");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (!cmd.wr_en && !cmd.out_load && !cmd.cnt_inc && !cmd.cnt_dec))
        else $error("table activity while idle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && sts.cnt != $past(sts.cnt)) |->
            (sts.cnt == $past(sts.cnt) + CNT_W'(1) ||
             sts.cnt == $past(sts.cnt) - CNT_W'(1)))
        else $error("entry count moved by more than one");

endmodule
